FILE: hw/rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// shared types, field positions and protocol codes for the socks connect
// detector
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PORT_W      = 16;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned AT_W        = 10;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [POS_W-1:0] POS_MAX = 9'd511;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_A = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_B = 8'd1;

    localparam logic [PORT_W-1:0] PORT_A_RESET = 16'd80;
    localparam logic [PORT_W-1:0] PORT_B_RESET = 16'd443;

    // byte positions in the payload
    localparam logic [POS_W-1:0] POS_VERSION = 9'd0;
    localparam logic [POS_W-1:0] POS_COMMAND = 9'd1;
    localparam logic [POS_W-1:0] POS_ATYP    = 9'd3;
    localparam logic [POS_W-1:0] POS_ADDR0   = 9'd4;
    localparam logic [POS_W-1:0] POS_ADDR1   = 9'd5;

    // position of the low port byte for each request form
    localparam logic [AT_W-1:0] AT_V4     = 10'd3;
    localparam logic [AT_W-1:0] AT_V5_IP4 = 10'd9;
    localparam logic [AT_W-1:0] AT_V5_DOM = 10'd6;
    localparam logic [AT_W-1:0] AT_V5_IP6 = 10'd21;

    // minimum lengths
    localparam logic [AT_W-1:0] LEN_MIN     = 10'd8;
    localparam logic [AT_W-1:0] LEN_V5_IP4  = 10'd10;
    localparam logic [AT_W-1:0] LEN_DOM_ADD = 10'd7;
    localparam logic [AT_W-1:0] LEN_V5_IP6  = 10'd22;

    // protocol codes
    localparam logic [BYTE_W-1:0] VER_SOCKS4  = 8'd4;
    localparam logic [BYTE_W-1:0] VER_SOCKS5  = 8'd5;
    localparam logic [BYTE_W-1:0] CMD_CONNECT = 8'd1;
    localparam logic [BYTE_W-1:0] ATYP_IPV4   = 8'd1;
    localparam logic [BYTE_W-1:0] ATYP_DOMAIN = 8'd3;
    localparam logic [BYTE_W-1:0] ATYP_IPV6   = 8'd4;

    // private ipv4 ranges
    localparam logic [BYTE_W-1:0] PRIV_NET10    = 8'd10;
    localparam logic [BYTE_W-1:0] PRIV_NET172   = 8'd172;
    localparam logic [BYTE_W-1:0] PRIV_NET192   = 8'd192;
    localparam logic [BYTE_W-1:0] PRIV_SUB168   = 8'd168;
    localparam logic [BYTE_W-1:0] PRIV_SUB172_LO = 8'd16;
    localparam logic [BYTE_W-1:0] PRIV_SUB172_HI = 8'd31;

    typedef struct packed {
        logic [PORT_W-1:0] port_a;
        logic [PORT_W-1:0] port_b;
    } scd_cfg_t;

    function automatic logic private_check(logic [BYTE_W-1:0] first,
                                           logic [BYTE_W-1:0] second);
        logic result;
        result = 1'b0;
        if (first == PRIV_NET10)
        begin
            result = 1'b1;
        end
        else if (first == PRIV_NET192)
        begin
            result = (second == PRIV_SUB168);
        end
        else if (first == PRIV_NET172)
        begin
            result = (second >= PRIV_SUB172_LO) && (second <= PRIV_SUB172_HI);
        end
        return result;
    endfunction

endpackage

FILE: hw/rtl/scd_cfg_regs.sv
// ----------------------------------------------------------------------------
// scd_cfg_regs
// watched destination port registers with a valid/ready write port
// ----------------------------------------------------------------------------
module scd_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scd_pkg::PORT_W-1:0]      cfg_data,
    output scd_pkg::scd_cfg_t               cfg
);
    import scd_pkg::*;

    logic [PORT_W-1:0] port_a_reg;
    logic [PORT_W-1:0] port_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg <= PORT_A_RESET;
            port_b_reg <= PORT_B_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PORT_A)
            begin
                port_a_reg <= cfg_data;
            end
            if (cfg_index == CFG_PORT_B)
            begin
                port_b_reg <= cfg_data;
            end
        end
    end

    assign cfg.port_a = port_a_reg;
    assign cfg.port_b = port_b_reg;

endmodule

FILE: hw/rtl/scd_parser.sv
// ----------------------------------------------------------------------------
// scd_parser
// per-packet header capture and connect decision, one byte per item
// ----------------------------------------------------------------------------
module scd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [scd_pkg::BYTE_W-1:0] data_byte,
    input  logic                       last_byte,
    input  scd_pkg::scd_cfg_t          cfg,
    output logic                       hit
);
    import scd_pkg::*;

    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [BYTE_W-1:0] ver_reg,   ver_next;
    logic [BYTE_W-1:0] cmd_reg,   cmd_next;
    logic [BYTE_W-1:0] kind_reg,  kind_next;
    logic [BYTE_W-1:0] len_reg,   len_next;
    logic [BYTE_W-1:0] first_reg, first_next;
    logic              priv_reg,  priv_next;
    logic [BYTE_W-1:0] hi_reg,    hi_next;
    logic              match_reg, match_next;

    logic [AT_W-1:0]   idx_w;
    logic [AT_W-1:0]   low_at;
    logic              low_sel;
    logic [PORT_W-1:0] port_val;
    logic [AT_W-1:0]   total;

    assign idx_w = {1'b0, pos_reg};

    always_comb
    begin
        ver_next   = (pos_reg == POS_VERSION) ? data_byte : ver_reg;
        cmd_next   = (pos_reg == POS_COMMAND) ? data_byte : cmd_reg;
        kind_next  = (pos_reg == POS_ATYP) ? data_byte : kind_reg;
        len_next   = (pos_reg == POS_ADDR0) ? data_byte : len_reg;
        first_next = (pos_reg == POS_ADDR0) ? data_byte : first_reg;
        priv_next  = (pos_reg == POS_ADDR1) ? private_check(first_reg, data_byte) : priv_reg;

        // where the low port byte sits for this request form
        low_sel = 1'b0;
        low_at  = '0;
        if (ver_next == VER_SOCKS4)
        begin
            low_sel = 1'b1;
            low_at  = AT_V4;
        end
        else if (ver_next == VER_SOCKS5 && pos_reg >= POS_ADDR0)
        begin
            if (kind_reg == ATYP_IPV4)
            begin
                low_sel = 1'b1;
                low_at  = AT_V5_IP4;
            end
            else if (kind_reg == ATYP_DOMAIN && pos_reg >= POS_ADDR1)
            begin
                low_sel = 1'b1;
                low_at  = AT_V5_DOM + {2'b00, len_reg};
            end
            else if (kind_reg == ATYP_IPV6)
            begin
                low_sel = 1'b1;
                low_at  = AT_V5_IP6;
            end
        end

        port_val   = {hi_reg, data_byte};
        hi_next    = hi_reg;
        match_next = match_reg;
        if (low_sel && (idx_w + 10'd1) == low_at)
        begin
            hi_next = data_byte;
        end
        else if (low_sel && idx_w == low_at)
        begin
            match_next = (port_val == cfg.port_a) || (port_val == cfg.port_b);
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 9'd1 : POS_MAX;
        total    = {1'b0, pos_next};

        hit = 1'b0;
        if (total >= LEN_MIN && match_next)
        begin
            if (ver_next == VER_SOCKS4)
            begin
                hit = !priv_next;
            end
            else if (ver_next == VER_SOCKS5 && cmd_next == CMD_CONNECT)
            begin
                if (kind_next == ATYP_IPV4)
                begin
                    hit = (total >= LEN_V5_IP4) && !priv_next;
                end
                else if (kind_next == ATYP_DOMAIN)
                begin
                    hit = total >= ({2'b00, len_next} + LEN_DOM_ADD);
                end
                else if (kind_next == ATYP_IPV6)
                begin
                    hit = total >= LEN_V5_IP6;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ver_reg   <= '0;
            cmd_reg   <= '0;
            kind_reg  <= '0;
            len_reg   <= '0;
            first_reg <= '0;
            priv_reg  <= 1'b0;
            hi_reg    <= '0;
            match_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // new packet starts clean
                pos_reg   <= '0;
                ver_reg   <= '0;
                cmd_reg   <= '0;
                kind_reg  <= '0;
                len_reg   <= '0;
                first_reg <= '0;
                priv_reg  <= 1'b0;
                hi_reg    <= '0;
                match_reg <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                ver_reg   <= ver_next;
                cmd_reg   <= cmd_next;
                kind_reg  <= kind_next;
                len_reg   <= len_next;
                first_reg <= first_next;
                priv_reg  <= priv_next;
                hi_reg    <= hi_next;
                match_reg <= match_next;
            end
        end
    end

endmodule

FILE: hw/rtl/socks_connect_detector.sv
// ----------------------------------------------------------------------------
// socks_connect_detector
// flags socks4 and socks5 connect requests to watched ports, one flag per packet
// ----------------------------------------------------------------------------
// Payload bytes enter one per cycle; every byte is an item and the block takes
// one each clock while the result register is free or being emptied. The item
// that carries last_byte yields one socks_connect result, registered and shown
// on the cycle after it is accepted; other bytes yield nothing. A result held
// by out_stall stalls the input until it is taken, so the rate is one byte per
// cycle, set by the single result register. The user must write the port
// registers via the cfg port only while no packet is in flight; not enforced.
module socks_connect_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [scd_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            socks_connect,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scd_pkg::PORT_W-1:0]      cfg_data
);
    import scd_pkg::*;

    scd_cfg_t cfg;
    logic     in_accept;
    logic     hit;
    logic     out_valid_reg, out_valid_next;
    logic     flag_reg,      flag_next;

    scd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cfg       (cfg),
        .hit       (hit)
    );

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        flag_next      = flag_reg;
        if (in_accept && last_byte)
        begin
            out_valid_next = 1'b1;
            flag_next      = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

    assign out_valid     = out_valid_reg;
    assign socks_connect = flag_reg;

`ifndef SYNTH
    // a last byte always produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_byte |=> out_valid)
        else $error("last byte gave no result");

    // a pending result blocks new bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !in_accept)
        else $error("byte accepted over pending result");

    // a non-last byte never invents a result
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && last_byte) && !(out_valid && out_stall) |=> !out_valid)
        else $error("result without last byte");

    // a held result keeps its flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(socks_connect))
        else $error("held result changed");
`endif

endmodule

FILE: verif/scd_checker.sv
// ----------------------------------------------------------------------------
// scd_checker
// Watches the byte, flag and port write channels of the socks connect
// detector. It keeps its own copy of the port registers and of the request
// fields captured so far. It works out the flag that each packet should give
// on its last byte and checks every flag item against the oldest one still
// due. Mismatches and unexpected flags are counted for the testbench top.
// ----------------------------------------------------------------------------
module scd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [scd_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            last_byte,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            socks_connect,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [scd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scd_pkg::PORT_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              flags_pending
);
    import scd_pkg::*;

    logic [PORT_W-1:0] watch_a;
    logic [PORT_W-1:0] watch_b;

    logic [POS_W-1:0]  seen;
    logic [BYTE_W-1:0] ver;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] atyp;
    logic [BYTE_W-1:0] dom_len;
    logic [BYTE_W-1:0] addr_hi;
    logic [BYTE_W-1:0] port_hi;
    logic              addr_private;
    logic              port_hit;

    logic connect_flags_due[$];
    logic due_flag;

    function automatic logic in_private_range(input logic [BYTE_W-1:0] net,
                                              input logic [BYTE_W-1:0] sub);
        case (net)
            PRIV_NET10:  return 1'b1;
            PRIV_NET172: return (sub >= PRIV_SUB172_LO) && (sub <= PRIV_SUB172_HI);
            PRIV_NET192: return sub == PRIV_SUB168;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic clear_packet();
        seen         = '0;
        ver          = '0;
        cmd          = '0;
        atyp         = '0;
        dom_len      = '0;
        addr_hi      = '0;
        port_hi      = '0;
        addr_private = 1'b0;
        port_hit     = 1'b0;
    endtask

    // fold one payload byte into the request fields, queue the flag on the last
    task automatic track_request_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        int   idx;
        int   port_lo_at;
        int   total;
        logic hit;
        idx = int'(seen);
        if (idx == POS_VERSION)
            ver = b;
        else if (idx == POS_COMMAND)
            cmd = b;
        else if (idx == POS_ATYP)
            atyp = b;
        if (idx == POS_ADDR0)
        begin
            dom_len = b;
            addr_hi = b;
        end
        else if (idx == POS_ADDR1)
        begin
            addr_private = in_private_range(addr_hi, b);
        end

        port_lo_at = -1;
        if (ver == VER_SOCKS4)
        begin
            port_lo_at = int'(AT_V4);
        end
        else if (ver == VER_SOCKS5 && idx >= POS_ADDR0)
        begin
            if (atyp == ATYP_IPV4)
                port_lo_at = int'(AT_V5_IP4);
            else if (atyp == ATYP_DOMAIN && idx >= POS_ADDR1)
                port_lo_at = int'(AT_V5_DOM) + int'(dom_len);
            else if (atyp == ATYP_IPV6)
                port_lo_at = int'(AT_V5_IP6);
        end
        if (port_lo_at >= 0)
        begin
            if (idx + 1 == port_lo_at)
                port_hi = b;
            else if (idx == port_lo_at)
                port_hit = ({port_hi, b} == watch_a) || ({port_hi, b} == watch_b);
        end

        seen = (seen == POS_MAX) ? POS_MAX : seen + 1'b1;
        if (is_last)
        begin
            total = int'(seen);
            hit   = 1'b0;
            if (total >= LEN_MIN && port_hit)
            begin
                if (ver == VER_SOCKS4)
                begin
                    hit = !addr_private;
                end
                else if (ver == VER_SOCKS5 && cmd == CMD_CONNECT)
                begin
                    case (atyp)
                        ATYP_IPV4:   hit = (total >= LEN_V5_IP4) && !addr_private;
                        ATYP_DOMAIN: hit = total >= dom_len + LEN_DOM_ADD;
                        ATYP_IPV6:   hit = total >= LEN_V5_IP6;
                        default:     hit = 1'b0;
                    endcase
                end
            end
            connect_flags_due.push_back(hit);
            clear_packet();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_a = PORT_A_RESET;
            watch_b = PORT_B_RESET;
            clear_packet();
            connect_flags_due.delete();
            fail_count    <= 0;
            flags_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PORT_A)
                    watch_a = cfg_data;
                else if (cfg_index == CFG_PORT_B)
                    watch_b = cfg_data;
            end
            if (in_valid && !in_stall)
                track_request_byte(data_byte, last_byte);
            if (out_valid && !out_stall)
            begin
                if (connect_flags_due.size() == 0)
                begin
                    $error("socks_connect: no flag due, actual %0d", socks_connect);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    due_flag = connect_flags_due.pop_front();
                    if (socks_connect !== due_flag)
                    begin
                        $error("socks_connect: expected %0d, actual %0d",
                               due_flag, socks_connect);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            flags_pending <= connect_flags_due.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the socks connect detector with payload bytes and port writes.
// A directed set covers each request form, the private ranges, the short
// payload cases and a payload long enough to saturate the byte counter.
// Then random packets follow, mostly well-formed requests with random
// fields and lengths, the rest noise. Ports are rewritten between phases.
// Both sides idle at random. The checker beside the block does the checking.
// ----------------------------------------------------------------------------
module testbench;
    import scd_pkg::*;

    localparam int ITEM_TARGET    = 1850;
    localparam int PHASE_BYTES    = 200;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      data_byte     = '0;
    logic                   last_byte     = 1'b0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic                   socks_connect;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [PORT_W-1:0]      cfg_data      = '0;

    int fail_count;
    int flags_pending;

    logic [PORT_W-1:0] cur_port_a = PORT_A_RESET;
    logic [PORT_W-1:0] cur_port_b = PORT_B_RESET;
    logic [BYTE_W-1:0] frame_bytes[$];
    int                bytes_sent   = 0;
    int                stall_left   = 0;
    int                quiet_cycles = 0;
    bit                tx_idle      = 1'b1;
    bit                rx_idle      = 1'b1;

    socks_connect_detector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .socks_connect (socks_connect),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    scd_checker flag_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .socks_connect (socks_connect),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .flags_pending (flags_pending)
    );

    always #5 clk = ~clk;

    // flag receiver: stalls flag items at random while in its idle mode
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && stall_left > 0)
            begin
                stall_left = stall_left - 1;
            end
            else if (out_valid)
            begin
                if ($urandom_range(0, 15) == 0)
                    rx_idle = !rx_idle;
                stall_left = rx_idle ? $urandom_range(0, 11) : 0;
            end
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        rand_byte = BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic is_last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        tx_idle = ($urandom_range(0, 3) != 0);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // builds the request in its usual layout, then trims or pads by len_adj
    task automatic send_request(input logic [BYTE_W-1:0] ver, input logic [BYTE_W-1:0] cmd,
                                input logic [BYTE_W-1:0] atyp, input logic [PORT_W-1:0] port,
                                input logic [BYTE_W-1:0] a0, input logic [BYTE_W-1:0] a1,
                                input logic [BYTE_W-1:0] dlen, input int len_adj);
        int n;
        frame_bytes.delete();
        frame_bytes.push_back(ver);
        frame_bytes.push_back(cmd);
        if (ver == VER_SOCKS4)
        begin
            frame_bytes.push_back(port[15:8]);
            frame_bytes.push_back(port[7:0]);
            frame_bytes.push_back(a0);
            frame_bytes.push_back(a1);
            repeat (2) frame_bytes.push_back(rand_byte());
        end
        else
        begin
            frame_bytes.push_back(rand_byte());
            frame_bytes.push_back(atyp);
            case (atyp)
                ATYP_IPV4:
                begin
                    frame_bytes.push_back(a0);
                    frame_bytes.push_back(a1);
                    repeat (2) frame_bytes.push_back(rand_byte());
                    frame_bytes.push_back(port[15:8]);
                    frame_bytes.push_back(port[7:0]);
                end
                ATYP_DOMAIN:
                begin
                    frame_bytes.push_back(dlen);
                    repeat (dlen) frame_bytes.push_back(rand_byte());
                    frame_bytes.push_back(port[15:8]);
                    frame_bytes.push_back(port[7:0]);
                end
                ATYP_IPV6:
                begin
                    frame_bytes.push_back(a0);
                    frame_bytes.push_back(a1);
                    repeat (14) frame_bytes.push_back(rand_byte());
                    frame_bytes.push_back(port[15:8]);
                    frame_bytes.push_back(port[7:0]);
                end
                default:
                begin
                    repeat (6) frame_bytes.push_back(rand_byte());
                end
            endcase
        end
        n = frame_bytes.size() + len_adj;
        if (n < 1)
            n = 1;
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
        while (frame_bytes.size() < n) frame_bytes.push_back(rand_byte());
        send_frame();
    endtask

    task automatic send_random_frame();
        int                pick;
        int                n;
        int                len_adj;
        logic [BYTE_W-1:0] ver;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] atyp;
        logic [BYTE_W-1:0] a0;
        logic [BYTE_W-1:0] a1;
        logic [BYTE_W-1:0] dlen;
        logic [PORT_W-1:0] port;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            n = $urandom_range(1, 24);
            frame_bytes.delete();
            repeat (n) frame_bytes.push_back(rand_byte());
            send_frame();
        end
        else
        begin
            pick = $urandom_range(0, 19);
            ver  = (pick < 7) ? VER_SOCKS4 : ((pick < 18) ? VER_SOCKS5 : rand_byte());
            cmd  = ($urandom_range(0, 7) != 0) ? CMD_CONNECT : rand_byte();
            pick = $urandom_range(0, 9);
            atyp = (pick < 3) ? ATYP_IPV4 : (pick < 6) ? ATYP_DOMAIN :
                   (pick < 8) ? ATYP_IPV6 : rand_byte();
            pick = $urandom_range(0, 9);
            port = (pick < 4) ? cur_port_a : (pick < 7) ? cur_port_b :
                   PORT_W'($urandom_range(0, 65535));
            a1   = rand_byte();
            case ($urandom_range(0, 4))
                0: a0 = PRIV_NET10;
                1:
                begin
                    a0 = PRIV_NET172;
                    a1 = BYTE_W'($urandom_range(14, 33));
                end
                2:
                begin
                    a0 = PRIV_NET192;
                    a1 = BYTE_W'($urandom_range(166, 170));
                end
                default: a0 = rand_byte();
            endcase
            dlen = ($urandom_range(0, 39) == 0) ? rand_byte() : BYTE_W'($urandom_range(0, 20));
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len_adj = 0;
            else if (pick < 8)
                len_adj = 0 - int'($urandom_range(1, 4));
            else
                len_adj = $urandom_range(1, 10);
            send_request(ver, cmd, atyp, port, a0, a1, dlen, len_adj);
        end
    endtask

    task automatic wait_flags_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (flags_pending != 0) @(posedge clk);
    endtask

    task automatic write_ports(input logic [PORT_W-1:0] port_a, input logic [PORT_W-1:0] port_b);
        wait_flags_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PORT_A;
        cfg_data  <= port_a;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_PORT_B;
        cfg_data  <= port_b;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_port_a = port_a;
        cur_port_b = port_b;
    endtask

    initial
    begin
        int                phase;
        int                next_phase_at;
        logic [PORT_W-1:0] same_port;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // socks4: public hit, private, short, unwatched port
        send_request(VER_SOCKS4, CMD_CONNECT, 8'd0, cur_port_a, 8'd8, 8'd8, 8'd0, 0);
        send_request(VER_SOCKS4, CMD_CONNECT, 8'd0, cur_port_b, PRIV_NET10, 8'd0, 8'd0, 0);
        send_request(VER_SOCKS4, CMD_CONNECT, 8'd0, cur_port_a, 8'd8, 8'd8, 8'd0, -1);
        send_request(VER_SOCKS4, CMD_CONNECT, 8'd0, 16'd81, 8'd8, 8'd8, 8'd0, 0);
        // socks5 ipv4 around the private ranges, and a short one
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV4, cur_port_b, PRIV_NET192, PRIV_SUB168,
                     8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV4, cur_port_b, PRIV_NET192, 8'd169, 8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV4, cur_port_a, PRIV_NET172, PRIV_SUB172_LO,
                     8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV4, cur_port_a, PRIV_NET172, PRIV_SUB172_HI,
                     8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV4, cur_port_a, PRIV_NET172, 8'd15, 8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV4, cur_port_b, PRIV_NET172, 8'd32, 8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV4, cur_port_a, 8'd1, 8'd2, 8'd0, -1);
        // socks5 domain at the length edge, empty name
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_DOMAIN, cur_port_a, 8'd0, 8'd0, 8'd3, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_DOMAIN, cur_port_a, 8'd0, 8'd0, 8'd3, -1);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_DOMAIN, cur_port_b, 8'd0, 8'd0, 8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_DOMAIN, cur_port_b, 8'd0, 8'd0, 8'd0, 1);
        // socks5 ipv6 full and short
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV6, cur_port_b, 8'hFF, 8'hFF, 8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, ATYP_IPV6, cur_port_b, 8'd0, 8'd0, 8'd0, -1);
        // unknown command, address type and versions
        send_request(VER_SOCKS5, 8'd2, ATYP_IPV4, cur_port_a, 8'd8, 8'd8, 8'd0, 0);
        send_request(VER_SOCKS5, CMD_CONNECT, 8'd2, cur_port_a, 8'd8, 8'd8, 8'd0, 0);
        send_request(8'd0, CMD_CONNECT, ATYP_IPV4, cur_port_a, 8'd8, 8'd8, 8'd0, 0);
        send_request(8'hFF, CMD_CONNECT, ATYP_IPV4, cur_port_a, 8'd8, 8'd8, 8'd0, 0);
        // one-byte payloads
        send_request(8'hFF, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, -100);
        send_request(8'h00, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, -100);
        // payload past the counter limit
        send_request(VER_SOCKS4, CMD_CONNECT, 8'd0, cur_port_a, 8'd8, 8'd8, 8'd0, 512);

        phase         = 0;
        next_phase_at = bytes_sent;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent >= next_phase_at)
            begin
                phase++;
                case (phase)
                    1: write_ports(16'h0000, 16'hFFFF);
                    2: write_ports(16'hFFFF, 16'h0000);
                    3:
                    begin
                        same_port = PORT_W'($urandom_range(0, 65535));
                        write_ports(same_port, same_port);
                    end
                    4: write_ports(PORT_A_RESET, PORT_B_RESET);
                    default: write_ports(PORT_W'($urandom_range(0, 65535)),
                                         PORT_W'($urandom_range(0, 65535)));
                endcase
                next_phase_at = bytes_sent + PHASE_BYTES;
            end
            send_random_frame();
        end

        wait_flags_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && flags_pending == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
